// ===== sv/rrts_pkg.sv =====
`timescale 1ns / 1ps

package rrts_pkg;

  localparam int MAX_THREADS_D      = 8;
  localparam int SECOND_TIME_STEP_D = 100;

  localparam int KIND_W   = 3;
  localparam int TGT_W    = 3;
  localparam int TICKS_W  = 16;
  localparam int THR_W    = 3;
  localparam int TOTAL_W  = 4;
  localparam int STAT_W   = 2;
  localparam int COUNT_W  = 16;
  localparam int TIME_W   = 32;

  // Event kinds
  localparam logic [KIND_W-1:0] KIND_TICK   = 3'd0;
  localparam logic [KIND_W-1:0] KIND_SECOND = 3'd1;
  localparam logic [KIND_W-1:0] KIND_SLEEP  = 3'd2;
  localparam logic [KIND_W-1:0] KIND_YIELD  = 3'd3;
  localparam logic [KIND_W-1:0] KIND_CREATE = 3'd4;
  localparam logic [KIND_W-1:0] KIND_SWITCH = 3'd5;

  // Thread states
  localparam logic [STAT_W-1:0] ST_READY    = 2'd0;
  localparam logic [STAT_W-1:0] ST_RUNNING  = 2'd1;
  localparam logic [STAT_W-1:0] ST_SLEEPING = 2'd2;
  localparam logic [STAT_W-1:0] ST_NONE     = 2'd3;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_SWEEP_TICK,
    OP_SWEEP_SEC,
    OP_SLEEP,
    OP_CREATE,
    OP_SWITCH,
    OP_SCAN_INIT,
    OP_SCAN,
    OP_DEMOTE,
    OP_PROMOTE,
    OP_KEEP,
    OP_QSET,
    OP_RESULT
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
  } dp_cmd_t;

  typedef struct packed {
    logic n_zero;
    logic sweep_last;
    logic created;
    logic sw_ok;
    logic scan_done;
    logic scan_pick;
    logic tick_event;
  } dp_stat_t;

endpackage

// ===== sv/rrts_if.sv =====
`timescale 1ns / 1ps

interface rrts_evt_if;
  import rrts_pkg::*;

  logic                valid;
  logic                ready;
  logic [KIND_W-1:0]   kind;
  logic [TGT_W-1:0]    target_thread;
  logic [TICKS_W-1:0]  sleep_ticks;

  modport source (output valid, kind, target_thread, sleep_ticks, input ready);
  modport sink   (input valid, kind, target_thread, sleep_ticks, output ready);
endinterface

interface rrts_res_if;
  import rrts_pkg::*;

  logic                valid;
  logic                ready;
  logic [THR_W-1:0]    running_thread;
  logic [THR_W-1:0]    previous_thread;
  logic                switched;
  logic                create_ok;
  logic [TOTAL_W-1:0]  thread_total;
  logic [STAT_W-1:0]   queried_status;
  logic [COUNT_W-1:0]  queried_last_count;
  logic [COUNT_W-1:0]  last_second_ticks;
  logic [TIME_W-1:0]   system_time;

  modport source (output valid, running_thread, previous_thread, switched, create_ok,
                  thread_total, queried_status, queried_last_count, last_second_ticks,
                  system_time, input ready);
  modport sink   (input valid, running_thread, previous_thread, switched, create_ok,
                  thread_total, queried_status, queried_last_count, last_second_ticks,
                  system_time, output ready);
endinterface

// ===== sv/rrts_datapath.sv =====
`timescale 1ns / 1ps

module rrts_datapath #(
  parameter int MAX_THREADS_P    = rrts_pkg::MAX_THREADS_D,
  parameter int SECOND_TIME_STEP = rrts_pkg::SECOND_TIME_STEP_D
) (
  input  logic                          clk,
  input  logic                          rst,
  input  rrts_pkg::dp_cmd_t             cmd,
  output rrts_pkg::dp_stat_t            stat,
  input  logic [rrts_pkg::KIND_W-1:0]   evt_kind,
  input  logic [rrts_pkg::TGT_W-1:0]    evt_target,
  input  logic [rrts_pkg::TICKS_W-1:0]  evt_ticks,
  output logic [rrts_pkg::THR_W-1:0]    running_thread,
  output logic [rrts_pkg::THR_W-1:0]    previous_thread,
  output logic                          switched,
  output logic                          create_ok,
  output logic [rrts_pkg::TOTAL_W-1:0]  thread_total,
  output logic [rrts_pkg::STAT_W-1:0]   queried_status,
  output logic [rrts_pkg::COUNT_W-1:0]  queried_last_count,
  output logic [rrts_pkg::COUNT_W-1:0]  last_second_ticks,
  output logic [rrts_pkg::TIME_W-1:0]   system_time
);
  import rrts_pkg::*;

  localparam int TW = $clog2(MAX_THREADS_P);
  localparam int CW = $clog2(MAX_THREADS_P + 1);
  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  logic [STAT_W-1:0]  thread_state     [MAX_THREADS_P];
  logic [COUNT_W-1:0] sleep_left       [MAX_THREADS_P];
  logic [COUNT_W-1:0] sched_count      [MAX_THREADS_P];
  logic [COUNT_W-1:0] last_sched_count [MAX_THREADS_P];

  logic [TW-1:0]      cur, prev, idx, pick;
  logic [CW-1:0]      n, cnt;
  logic [KIND_W-1:0]  kind_q;
  logic [TGT_W-1:0]   target_q;
  logic [TICKS_W-1:0] ticks_q;
  logic               made, zero_ready;
  logic [COUNT_W-1:0] tick_cnt, last_tick;
  logic [TIME_W-1:0]  time_cnt;

  logic [STAT_W-1:0]  st_rd;
  logic [COUNT_W-1:0] sl_rd, sc_rd, ls_rd, sc_inc;
  logic               idx_last, cur_last, target_ok, has_room;
  logic               ready_hit, zero_any, scan_end;
  logic [TW-1:0]      idx_inc, cur_inc;

  always_comb begin
    st_rd     = thread_state[idx];
    sl_rd     = sleep_left[idx];
    sc_rd     = sched_count[idx];
    ls_rd     = last_sched_count[idx];
    sc_inc    = (sc_rd == COUNT_MAX) ? sc_rd : sc_rd + COUNT_W'(1);
    idx_last  = (CW'(idx) + CW'(1)) == n;
    cur_last  = (CW'(cur) + CW'(1)) == n;
    idx_inc   = idx_last ? '0 : idx + TW'(1);
    cur_inc   = cur_last ? '0 : cur + TW'(1);
    target_ok = int'(target_q) < MAX_THREADS_P;
    has_room  = int'(n) < MAX_THREADS_P;
    ready_hit = (st_rd == ST_READY) && (idx != '0);
    zero_any  = zero_ready || ((st_rd == ST_READY) && (idx == '0));
    scan_end  = cnt == n;

    stat.n_zero     = n == '0;
    stat.sweep_last = idx_last;
    stat.created    = st_rd != ST_NONE;
    stat.sw_ok      = target_ok && (st_rd != ST_NONE);
    stat.scan_done  = ready_hit || scan_end;
    stat.scan_pick  = ready_hit || zero_any;
    stat.tick_event = kind_q == KIND_TICK;
  end

  // Thread state table: the only per-thread store with a reset value
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MAX_THREADS_P; i++) begin
        thread_state[i] <= ST_NONE;
      end
    end else begin
      case (cmd.op)
        OP_SWEEP_TICK: begin
          if (sl_rd == COUNT_W'(1)) thread_state[idx] <= ST_READY;
        end
        OP_SLEEP: begin
          if (st_rd != ST_NONE && ticks_q != '0) thread_state[idx] <= ST_SLEEPING;
        end
        OP_CREATE: begin
          if (has_room) thread_state[idx] <= ST_READY;
        end
        OP_DEMOTE: begin
          if (cur != pick && st_rd == ST_RUNNING) thread_state[idx] <= ST_READY;
        end
        OP_PROMOTE: begin
          thread_state[idx] <= ST_RUNNING;
        end
        default: begin
        end
      endcase
    end
  end

  // Counters per thread; entries are cleared on create before any read
  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_SWEEP_TICK: begin
        if (sl_rd != '0) sleep_left[idx] <= sl_rd - COUNT_W'(1);
      end
      OP_SWEEP_SEC: begin
        last_sched_count[idx] <= sc_rd;
        sched_count[idx]      <= '0;
      end
      OP_SLEEP: begin
        if (st_rd != ST_NONE && ticks_q != '0) sleep_left[idx] <= ticks_q;
      end
      OP_CREATE: begin
        if (has_room) begin
          sleep_left[idx]       <= '0;
          sched_count[idx]      <= '0;
          last_sched_count[idx] <= '0;
        end
      end
      OP_SWITCH: begin
        if (target_ok && st_rd != ST_NONE) sleep_left[idx] <= '0;
      end
      OP_PROMOTE: begin
        sched_count[idx] <= sc_inc;
      end
      OP_KEEP: begin
        if (st_rd == ST_RUNNING) sched_count[idx] <= sc_inc;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur        <= '0;
      prev       <= '0;
      idx        <= '0;
      pick       <= '0;
      n          <= '0;
      cnt        <= '0;
      kind_q     <= '0;
      target_q   <= '0;
      ticks_q    <= '0;
      made       <= 1'b0;
      zero_ready <= 1'b0;
      tick_cnt   <= '0;
      last_tick  <= '0;
      time_cnt   <= '0;
    end else begin
      case (cmd.op)
        OP_LOAD: begin
          kind_q     <= evt_kind;
          target_q   <= evt_target;
          ticks_q    <= evt_ticks;
          prev       <= cur;
          made       <= 1'b0;
          zero_ready <= 1'b0;
          case (evt_kind)
            KIND_TICK: begin
              idx <= '0;
              if (tick_cnt != COUNT_MAX) tick_cnt <= tick_cnt + COUNT_W'(1);
            end
            KIND_SECOND: begin
              idx       <= '0;
              last_tick <= tick_cnt;
              tick_cnt  <= '0;
              time_cnt  <= time_cnt + TIME_W'(SECOND_TIME_STEP);
            end
            KIND_SLEEP:  idx <= cur;
            KIND_CREATE: idx <= TW'(n);
            KIND_SWITCH: idx <= TW'(evt_target);
            default:     idx <= '0;
          endcase
        end
        OP_SWEEP_TICK, OP_SWEEP_SEC: begin
          idx <= idx_inc;
        end
        OP_CREATE: begin
          if (has_room) begin
            n    <= n + CW'(1);
            made <= 1'b1;
          end
        end
        OP_SWITCH: begin
          pick <= idx;
          idx  <= cur;
        end
        OP_SCAN_INIT: begin
          idx <= cur_inc;
          cnt <= CW'(1);
        end
        OP_SCAN: begin
          if (st_rd == ST_READY && idx == '0) zero_ready <= 1'b1;
          cnt <= cnt + CW'(1);
          idx <= idx_inc;
          if (ready_hit) begin
            pick <= idx;
            idx  <= cur;
          end else if (scan_end) begin
            pick <= '0;
            idx  <= cur;
          end
        end
        OP_DEMOTE: begin
          cur <= pick;
          idx <= pick;
        end
        OP_QSET: begin
          idx <= TW'(target_q);
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == OP_RESULT) begin
      running_thread     <= THR_W'(cur);
      previous_thread    <= THR_W'(prev);
      switched           <= cur != prev;
      create_ok          <= made;
      thread_total       <= TOTAL_W'(n);
      queried_status     <= target_ok ? st_rd : ST_NONE;
      queried_last_count <= (target_ok && st_rd != ST_NONE) ? ls_rd : '0;
      last_second_ticks  <= last_tick;
      system_time        <= time_cnt;
    end
  end

  logic [MAX_THREADS_P-1:0] run_vec;

  always_comb begin
    for (int i = 0; i < MAX_THREADS_P; i++) begin
      run_vec[i] = thread_state[i] == ST_RUNNING;
    end
  end

  a_one_running: assert property (@(posedge clk) disable iff (rst)
    $countones(run_vec) <= 1)
    else $error("more than one thread marked running");

  a_cur_created: assert property (@(posedge clk) disable iff (rst)
    (n != '0) |-> (CW'(cur) < n))
    else $error("current thread beyond created range");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    int'(n) <= MAX_THREADS_P)
    else $error("thread count overflow");

  a_made_src: assert property (@(posedge clk) disable iff (rst)
    $rose(made) |-> $past(cmd.op) == OP_CREATE)
    else $error("create flag set outside a create");

endmodule

// ===== sv/rrts_ctrl.sv =====
`timescale 1ns / 1ps

module rrts_ctrl (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         evt_valid,
  output logic                         evt_ready,
  input  logic [rrts_pkg::KIND_W-1:0]  evt_kind,
  output logic                         res_valid,
  input  logic                         res_ready,
  output rrts_pkg::dp_cmd_t            cmd,
  input  rrts_pkg::dp_stat_t           stat
);
  import rrts_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_SWEEP, S_PICK, S_SCAN, S_SLEEP, S_CREATE, S_SWITCH,
    S_DEMOTE, S_PROMOTE, S_KEEP, S_QSET, S_RESULT
  } state_t;

  state_t state, state_next;
  logic   res_free;

  assign evt_ready = state == S_IDLE;
  assign res_free  = !res_valid || res_ready;

  always_comb begin
    state_next = state;
    cmd.op     = OP_NONE;
    case (state)
      S_IDLE: begin
        if (evt_valid) begin
          cmd.op = OP_LOAD;
          case (evt_kind)
            KIND_TICK, KIND_SECOND: state_next = S_SWEEP;
            KIND_SLEEP:             state_next = S_SLEEP;
            KIND_YIELD:             state_next = S_PICK;
            KIND_CREATE:            state_next = S_CREATE;
            KIND_SWITCH:            state_next = S_SWITCH;
            default:                state_next = S_QSET;
          endcase
        end
      end
      S_SWEEP: begin
        if (!stat.n_zero) cmd.op = stat.tick_event ? OP_SWEEP_TICK : OP_SWEEP_SEC;
        if (stat.n_zero || stat.sweep_last) begin
          state_next = stat.tick_event ? S_PICK : S_QSET;
        end
      end
      S_PICK: begin
        if (stat.n_zero) begin
          state_next = S_QSET;
        end else begin
          cmd.op     = OP_SCAN_INIT;
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.op = OP_SCAN;
        if (stat.scan_done) state_next = stat.scan_pick ? S_DEMOTE : S_KEEP;
      end
      S_SLEEP: begin
        cmd.op     = OP_SLEEP;
        state_next = stat.created ? S_PICK : S_QSET;
      end
      S_CREATE: begin
        cmd.op     = OP_CREATE;
        state_next = S_QSET;
      end
      S_SWITCH: begin
        cmd.op     = OP_SWITCH;
        state_next = stat.sw_ok ? S_DEMOTE : S_QSET;
      end
      S_DEMOTE: begin
        cmd.op     = OP_DEMOTE;
        state_next = S_PROMOTE;
      end
      S_PROMOTE: begin
        cmd.op     = OP_PROMOTE;
        state_next = S_QSET;
      end
      S_KEEP: begin
        cmd.op     = OP_KEEP;
        state_next = S_QSET;
      end
      S_QSET: begin
        cmd.op     = OP_QSET;
        state_next = S_RESULT;
      end
      S_RESULT: begin
        if (res_free) begin
          cmd.op     = OP_RESULT;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      res_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.op == OP_RESULT) begin
        res_valid <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  a_result_slot: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == OP_RESULT) |-> res_free)
    else $error("result written over an untaken transaction");

  a_result_from_fsm: assert property (@(posedge clk) disable iff (rst)
    $rose(res_valid) |-> $past(state) == S_RESULT)
    else $error("result raised outside the result step");

  a_load_idle: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == OP_LOAD) |=> (state != S_IDLE))
    else $error("event accepted without leaving idle");

endmodule

// ===== sv/round_robin_thread_scheduler.sv =====
`timescale 1ns / 1ps

// Round-robin scheduler for up to MAX_THREADS_P hardware threads. Each event
// transaction on evt (tick, second tick, sleep, yield, create, switch) yields
// exactly one result transaction on res, reporting the running thread before
// and after, the created-thread total, the status and last-second schedule
// count of target_thread, the last-second tick count and the system time.
// Thread 0 is the idle thread and is picked only when no other thread is
// ready. Per-thread state lives in a small table that is read and written at
// one entry per cycle, so cost follows the number of created threads n.
// A scheduling tick runs a countdown sweep over all created threads, then a
// round-robin scan of up to n entries; a second tick runs the sweep alone.
// One event is processed at a time; evt is taken again once the current event
// has moved its result into the output register, even while that result
// still waits.
module round_robin_thread_scheduler #(
  parameter int MAX_THREADS_P    = rrts_pkg::MAX_THREADS_D,
  parameter int SECOND_TIME_STEP = rrts_pkg::SECOND_TIME_STEP_D
) (
  input  logic         clk,
  input  logic         rst,
  rrts_evt_if.sink     evt,
  rrts_res_if.source   res
);
  import rrts_pkg::*;

  // Command and status between the sequencer and the thread table
  dp_cmd_t  cmd;
  dp_stat_t stat;

  rrts_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .evt_valid (evt.valid),
    .evt_ready (evt.ready),
    .evt_kind  (evt.kind),
    .res_valid (res.valid),
    .res_ready (res.ready),
    .cmd       (cmd),
    .stat      (stat)
  );

  // Thread table, counters and the result register
  rrts_datapath #(
    .MAX_THREADS_P    (MAX_THREADS_P),
    .SECOND_TIME_STEP (SECOND_TIME_STEP)
  ) u_datapath (
    .clk                (clk),
    .rst                (rst),
    .cmd                (cmd),
    .stat               (stat),
    .evt_kind           (evt.kind),
    .evt_target         (evt.target_thread),
    .evt_ticks          (evt.sleep_ticks),
    .running_thread     (res.running_thread),
    .previous_thread    (res.previous_thread),
    .switched           (res.switched),
    .create_ok          (res.create_ok),
    .thread_total       (res.thread_total),
    .queried_status     (res.queried_status),
    .queried_last_count (res.queried_last_count),
    .last_second_ticks  (res.last_second_ticks),
    .system_time        (res.system_time)
  );

endmodule
